/* hw/rtl/mvat_pkg.sv */
`timescale 1ns / 1ps

package mvat_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ID_BITS     = 16;
  localparam int VAL_W       = 32;
  localparam int STAMP_W     = 32;
  localparam int DRAW_W      = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = STAMP_W + IDX_W;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_SET    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_PICK   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]              op;
    logic [ID_BITS-1:0]      id;
    logic signed [VAL_W-1:0] val;
    logic [DRAW_W-1:0]       draw;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_BITS-1:0] best_id;
    logic [CNT_W-1:0]   count;
  } res_t;

  // Write side of the slot store.
  typedef struct packed {
    logic                    set_used;
    logic                    clr_slot;
    logic                    clr_all;
    logic                    id_we;
    logic                    val_we;
    logic [IDX_W-1:0]        waddr;
    logic [ID_BITS-1:0]      wid;
    logic signed [VAL_W-1:0] wval;
    logic [STAMP_W-1:0]      wstamp;
  } store_cmd_t;

  // Registered read data of one slot.
  typedef struct packed {
    logic                    used;
    logic                    has;
    logic [ID_BITS-1:0]      id;
    logic signed [VAL_W-1:0] val;
    logic [STAMP_W-1:0]      stamp;
  } store_rd_t;

endpackage

/* hw/rtl/mvat_store.sv */
`timescale 1ns / 1ps

module mvat_store
  import mvat_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_cmd_t       cmd_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output store_rd_t        rd_o
);

  logic [TABLE_DEPTH-1:0] used_q;
  logic [TABLE_DEPTH-1:0] has_q;
  logic [ID_BITS-1:0]      mem_id    [TABLE_DEPTH];
  logic signed [VAL_W-1:0] mem_val   [TABLE_DEPTH];
  logic [STAMP_W-1:0]      mem_stamp [TABLE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      has_q  <= '0;
    end else if (cmd_i.clr_all) begin
      used_q <= '0;
      has_q  <= '0;
    end else begin
      if (cmd_i.set_used) begin
        used_q[cmd_i.waddr] <= 1'b1;
        has_q[cmd_i.waddr]  <= 1'b0;
      end
      if (cmd_i.clr_slot) begin
        used_q[cmd_i.waddr] <= 1'b0;
        has_q[cmd_i.waddr]  <= 1'b0;
      end
      if (cmd_i.val_we) begin
        has_q[cmd_i.waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.id_we) begin
      mem_id[cmd_i.waddr] <= cmd_i.wid;
    end
    if (cmd_i.val_we) begin
      mem_val[cmd_i.waddr]   <= cmd_i.wval;
      mem_stamp[cmd_i.waddr] <= cmd_i.wstamp;
    end
    rd_o.id    <= mem_id[rd_addr_i];
    rd_o.val   <= mem_val[rd_addr_i];
    rd_o.stamp <= mem_stamp[rd_addr_i];
    rd_o.used  <= used_q[rd_addr_i];
    rd_o.has   <= has_q[rd_addr_i];
  end

endmodule

/* hw/rtl/mvat_divider.sv */
`timescale 1ns / 1ps

module mvat_divider
  import mvat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DRAW_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [IDX_W-1:0]  rem_o
);

  localparam int STEP_W = $clog2(DRAW_W + 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DRAW_W-1:0] dd_q, dd_d;
  logic [CNT_W-1:0]  dv_q, dv_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;

  // Restoring division, one dividend bit a cycle; only the remainder is kept.
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    dd_d   = dd_q;
    dv_d   = dv_q;
    rem_d  = rem_q;
    done_o = 1'b0;
    trial  = {rem_q, dd_q[DRAW_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dd_d   = dividend_i;
      dv_d   = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dd_d   = {dd_q[DRAW_W-2:0], 1'b0};
      step_d = step_q + STEP_W'(1);
      if (trial >= {1'b0, dv_q}) begin
        rem_d = CNT_W'(trial - {1'b0, dv_q});
      end else begin
        rem_d = CNT_W'(trial);
      end
      if (step_q == STEP_W'(DRAW_W - 1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign rem_o = rem_d[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dd_q  <= dd_d;
    dv_q  <= dv_d;
    rem_q <= rem_d;
  end

endmodule

/* hw/rtl/mvat_ctrl.sv */
`timescale 1ns / 1ps

module mvat_ctrl
  import mvat_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o,
  output store_cmd_t       cmd_o,
  output logic [IDX_W-1:0] rd_addr_o,
  input  store_rd_t        rd_i
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FIND  = 8'b0000_0010,
    S_VREAD = 8'b0000_0100,
    S_VCHK  = 8'b0000_1000,
    S_MIN   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_RANK  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [CNT_W-1:0]   iss_q, iss_d;
  logic               p_vld_q, p_vld_d;
  logic [IDX_W-1:0]   p_idx_q, p_idx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [STAMP_W-1:0] join_q, join_d;
  logic               found_q, found_d, free_q, free_d;
  logic [IDX_W-1:0]   slot_q, slot_d, fslot_q, fslot_d;
  logic               any_q, any_d;
  logic signed [VAL_W-1:0] min_q, min_d;
  logic [CNT_W-1:0]   ties_q, ties_d;
  logic [IDX_W-1:0]   pos_q, pos_d, rnd_q, rnd_d;
  logic               first_q, first_d, bfound_q, bfound_d;
  logic [KEY_W-1:0]   thr_q, thr_d, bkey_q, bkey_d;
  logic [ID_BITS-1:0] bid_q, bid_d, best_q, best_d;
  logic [1:0]         status_q, status_d;
  logic               div_go_q, div_go_d;
  logic               issuing, last, cand, div_start, div_done;
  logic [IDX_W-1:0]   div_rem;
  logic [KEY_W-1:0]   key;

  mvat_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_q.draw),
    .divisor_i  (ties_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // The remainder unit is started from a register, in the cycle after the minimum walk ends.
  assign div_start = div_go_q;

  // Tie order key: larger age first, then lower slot.
  assign key     = {join_q - rd_i.stamp, ~p_idx_q};
  assign issuing = (iss_q < CNT_W'(TABLE_DEPTH));
  assign last    = p_vld_q && (p_idx_q == IDX_W'(TABLE_DEPTH - 1));
  assign cand    = rd_i.used && rd_i.has && (rd_i.val == min_q) &&
                   (first_q || (key < thr_q));

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{status: status_q, best_id: best_q, count: cnt_q};

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    iss_d     = iss_q;
    p_vld_d   = 1'b0;
    p_idx_d   = iss_q[IDX_W-1:0];
    cnt_d     = cnt_q;
    join_d    = join_q;
    found_d   = found_q;
    free_d    = free_q;
    slot_d    = slot_q;
    fslot_d   = fslot_q;
    any_d     = any_q;
    min_d     = min_q;
    ties_d    = ties_q;
    pos_d     = pos_q;
    rnd_d     = rnd_q;
    first_d   = first_q;
    bfound_d  = bfound_q;
    thr_d     = thr_q;
    bkey_d    = bkey_q;
    bid_d     = bid_q;
    best_d    = best_q;
    status_d  = status_q;
    div_go_d  = 1'b0;
    cmd_o     = '0;
    rd_addr_o = iss_q[IDX_W-1:0];

    if ((state_q == S_FIND || state_q == S_MIN || state_q == S_RANK) && issuing) begin
      iss_d   = iss_q + CNT_W'(1);
      p_vld_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d    = req_i;
          iss_d    = '0;
          found_d  = 1'b0;
          free_d   = 1'b0;
          any_d    = 1'b0;
          status_d = ST_OK;
          best_d   = '0;
          unique case (op_e'(req_i.op))
            OP_INSERT, OP_SET, OP_REMOVE: state_d = S_FIND;
            OP_PICK: state_d = S_MIN;
            OP_CLEAR: begin
              cmd_o.clr_all = 1'b1;
              join_d        = '0;
              cnt_d         = '0;
              state_d       = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_FIND: begin
        if (p_vld_q) begin
          if (rd_i.used && rd_i.id == req_q.id && !found_q) begin
            found_d = 1'b1;
            slot_d  = p_idx_q;
          end
          if (!rd_i.used && !free_q) begin
            free_d  = 1'b1;
            fslot_d = p_idx_q;
          end
        end
        if (last) begin
          state_d     = S_DONE;
          cmd_o.wid   = req_q.id;
          cmd_o.waddr = fslot_d;
          if (op_e'(req_q.op) == OP_REMOVE) begin
            if (found_d) begin
              cmd_o.clr_slot = 1'b1;
              cmd_o.waddr    = slot_d;
              cnt_d          = cnt_q - CNT_W'(1);
            end else begin
              status_d = ST_ABSENT;
            end
          end else if (!found_d) begin
            if (free_d) begin
              cmd_o.set_used = 1'b1;
              cmd_o.id_we    = 1'b1;
              cnt_d          = cnt_q + CNT_W'(1);
              slot_d         = fslot_d;
              if (op_e'(req_q.op) == OP_SET) begin
                state_d = S_VREAD;
              end
            end else begin
              status_d = ST_FULL;
            end
          end else if (op_e'(req_q.op) == OP_SET) begin
            state_d = S_VREAD;
          end
        end
      end

      S_VREAD: begin
        rd_addr_o = slot_q;
        state_d   = S_VCHK;
      end

      S_VCHK: begin
        // A value equal to the stored one keeps the entry's place in the tie order.
        if (!rd_i.has || rd_i.val != req_q.val) begin
          cmd_o.val_we = 1'b1;
          cmd_o.waddr  = slot_q;
          cmd_o.wval   = req_q.val;
          cmd_o.wstamp = join_q;
          join_d       = join_q + STAMP_W'(1);
        end
        state_d = S_DONE;
      end

      S_MIN: begin
        if (p_vld_q && rd_i.used && rd_i.has) begin
          if (!any_q || rd_i.val < min_q) begin
            min_d  = rd_i.val;
            ties_d = CNT_W'(1);
            any_d  = 1'b1;
          end else if (rd_i.val == min_q) begin
            ties_d = ties_q + CNT_W'(1);
          end
        end
        if (last) begin
          if (!any_d) begin
            status_d = ST_EMPTY;
            state_d  = S_DONE;
          end else begin
            div_go_d = 1'b1;
            state_d  = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          pos_d    = div_rem;
          iss_d    = '0;
          rnd_d    = '0;
          first_d  = 1'b1;
          bfound_d = 1'b0;
          state_d  = S_RANK;
        end
      end

      S_RANK: begin
        // Each pass finds the next entry in the tie order below the last one found.
        if (p_vld_q && cand && (!bfound_q || key > bkey_q)) begin
          bkey_d   = key;
          bid_d    = rd_i.id;
          bfound_d = 1'b1;
        end
        if (last) begin
          if (rnd_q == pos_q) begin
            best_d  = bid_d;
            state_d = S_DONE;
          end else begin
            thr_d    = bkey_d;
            first_d  = 1'b0;
            bfound_d = 1'b0;
            rnd_d    = rnd_q + IDX_W'(1);
            iss_d    = '0;
          end
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      iss_q    <= '0;
      p_vld_q  <= 1'b0;
      cnt_q    <= '0;
      join_q   <= '0;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      p_vld_q  <= p_vld_d;
      cnt_q    <= cnt_d;
      join_q   <= join_d;
      div_go_q <= div_go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    p_idx_q  <= p_idx_d;
    found_q  <= found_d;
    free_q   <= free_d;
    slot_q   <= slot_d;
    fslot_q  <= fslot_d;
    any_q    <= any_d;
    min_q    <= min_d;
    ties_q   <= ties_d;
    pos_q    <= pos_d;
    rnd_q    <= rnd_d;
    first_q  <= first_d;
    bfound_q <= bfound_d;
    thr_q    <= thr_d;
    bkey_q   <= bkey_d;
    bid_q    <= bid_d;
    best_q   <= best_d;
    status_q <= status_d;
  end

endmodule

/* hw/rtl/min_value_action_table_top.sv */
`timescale 1ns / 1ps
// Table of up to 64 action ids, each with an optional signed value.
// Input channel s_axis: one operation per item, the opcode in tuser
// (insert, set value, remove, pick best, clear) and id, value and draw
// in tdata. Output channel m_axis: exactly one result item per input
// item, in order, status in tuser and best id plus entry count in tdata.
// The block takes one item at a time. Every slot walk reads one slot a
// cycle from the slot memories and visits all 64 slots. Clear and unused
// opcodes go straight to the result; insert, remove and a pick best on an
// empty table make one slot walk; set value, once it has a slot, then
// reads and compares that slot. Pick best walks for the minimum, runs the
// bit-serial remainder unit for k = draw mod tie count, then walks the
// whole table once per rank of the tie order, k + 1 times in all.
// Reset empties the table at once and sets the join counter to zero.
// A finished result sits in an output register; the next item is taken
// while it waits, and a further result is held until the receiver takes it.
module min_value_action_table_top
  import mvat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // entry_id[15:0], new_value[47:16], draw[63:48]
  input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // best_id[15:0], entry_count[22:16], zero[23]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  req_t             req;
  res_t             res;
  logic             res_valid, res_ready;
  store_cmd_t       cmd;
  store_rd_t        rd;
  logic [IDX_W-1:0] rd_addr;
  logic             out_vld_q;
  res_t             out_q;

  assign req = '{op: s_axis_tuser, id: s_axis_tdata[15:0],
                 val: s_axis_tdata[47:16], draw: s_axis_tdata[63:48]};

  mvat_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .rd_o      (rd)
  );

  mvat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .rd_i        (rd)
  );

  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.count, out_q.best_id};
  assign m_axis_tuser  = out_q.status;

endmodule

/* hw/rtl/mvat_checker.sv */
`timescale 1ns / 1ps

module mvat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // The table never reports more ids than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[22:16] <= 7'd64)
    else $error("entry count above table depth");

  // Only a successful operation carries a nonzero id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != 2'd0 |-> m_axis_tdata[15:0] == 16'd0)
    else $error("best id set on a failed operation");

  // One item is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while busy");

endmodule

bind min_value_action_table_top mvat_checker u_mvat_checker (.*);
